// File: design/plm_pkg.sv
// shared constants, register indexes and the full-scale log constant for the level meter
package plm_pkg;

  // default configuration of the meter
  localparam int COUNT_WIDTH_DEF  = 16;
  localparam int DB_FRAC_BITS_DEF = 8;

  // field and datapath widths
  localparam int SAMPLE_W   = 16;
  localparam int LEVEL_W    = 15;
  localparam int DB_W       = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int SUM_W      = 46;
  localparam int ROOT_W     = SUM_W / 2;
  localparam int LOG_FRAC   = 24;
  localparam int LOG_W      = 28;
  localparam int MUL_W      = 31;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int DB_MAG_W   = 17;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_LEVEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FLOOR_DB    = 2'd2;

  // register reset values
  localparam logic [15:0] WINDOW_LEN_RST  = 16'd1470;
  localparam logic [14:0] FLOOR_LEVEL_RST = 15'd33;
  localparam logic [15:0] FLOOR_DB_RST    = 16'hc400;

  // level and dB constants
  localparam logic [LEVEL_W-1:0]  FULL_SCALE = 15'h7fff;
  localparam logic [26:0]         DB_K       = 27'd101008905;
  localparam logic [DB_MAG_W-1:0] DB_MAG_MAX = 17'd32768;

  // log2 of a level in Q24, same squaring recurrence as the hardware loop
  function automatic logic [LOG_W-1:0] log2_q24(input logic [LEVEL_W-1:0] x);
    int unsigned e;
    longint unsigned m;
    logic [LOG_W-1:0] res;
    e = 0;
    for (int k = 1; k < LEVEL_W; k++) begin
      if (x[k]) e = k;
    end
    m = longint'(x) << (30 - e);
    res = LOG_W'(e) << LOG_FRAC;
    for (int i = LOG_FRAC - 1; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        res[i] = 1'b1;
        m = m >> 1;
      end
    end
    return res;
  endfunction

  localparam logic [LOG_W-1:0] LOG2_FULL_SCALE = log2_q24(FULL_SCALE);

endpackage

// File: design/peak_rms_level_meter.sv
// peak and rms level meter with linear and dB outputs over a sample window
// A sample that does not close a window holds the input stalled through the ACC and SUM states.
// A closing sample stalls the input through 46 divide steps, 23 root steps and up to two log passes
// on the shared 31x31 multiplier, then through any wait for a free output register and the output load.
// The output register lets the next window fill while a result waits to be taken.
// Synchronous reset clears the accumulators and output valid and loads register defaults.
module peak_rms_level_meter #(
  parameter int COUNT_WIDTH  = plm_pkg::COUNT_WIDTH_DEF,
  parameter int DB_FRAC_BITS = plm_pkg::DB_FRAC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic signed [plm_pkg::SAMPLE_W-1:0]   sample,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic        [plm_pkg::LEVEL_W-1:0]    peak_level,
  output logic        [plm_pkg::LEVEL_W-1:0]    rms_level,
  output logic signed [plm_pkg::DB_W-1:0]       peak_db,
  output logic signed [plm_pkg::DB_W-1:0]       rms_db,
  input  logic                                  cfg_write,
  input  logic        [plm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic        [plm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import plm_pkg::*;

  localparam int CMP_W      = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int SQ_REM_W   = ROOT_W + 1;
  localparam int RND_SH     = 48 - DB_FRAC_BITS;
  localparam int DIV_STEPS  = SUM_W;
  localparam int SQRT_STEPS = ROOT_W;

  typedef enum logic [8:0] {
    ST_IDLE     = 9'b000000001,
    ST_ACC      = 9'b000000010,
    ST_SUM      = 9'b000000100,
    ST_DIV      = 9'b000001000,
    ST_SQRT     = 9'b000010000,
    ST_LOG_INIT = 9'b000100000,
    ST_LOG_SQ   = 9'b001000000,
    ST_LOG_MUL  = 9'b010000000,
    ST_FINISH   = 9'b100000000
  } state_t;

  // control state
  state_t state;
  logic [5:0] step;
  logic log_sel;
  logic log_rnd;

  // configuration registers
  logic [15:0] window_len;
  logic [14:0] floor_level;
  logic [15:0] floor_db;

  // accumulators, sum doubles as dividend / quotient / root operand shifter
  logic [LEVEL_W-1:0] peak;
  logic [SUM_W-1:0] sum;
  logic [COUNT_WIDTH-1:0] count;

  // datapath registers
  logic [LEVEL_W-1:0] mag_r;
  logic [COUNT_WIDTH-1:0] div_rem;
  logic [SQ_REM_W-1:0] sq_rem;
  logic [ROOT_W-1:0] root;
  logic [MUL_W-1:0] mres;
  logic [LOG_W-1:0] lres;
  logic zero_flag;
  logic [DB_W-1:0] pdb;
  logic [DB_W-1:0] rdb;
  logic [PROD_W-1:0] mul_q;

  assign in_stall = (state != ST_IDLE);

  // sample magnitude, most negative value saturates to full scale
  logic [SAMPLE_W-1:0] mag_full;
  logic [LEVEL_W-1:0] mag;
  assign mag_full = sample[SAMPLE_W-1] ? SAMPLE_W'(-sample) : SAMPLE_W'(sample);
  assign mag = mag_full[SAMPLE_W-1] ? FULL_SCALE : mag_full[LEVEL_W-1:0];

  // shared multiplier: square of sample, log squaring, dB scaling
  logic [MUL_W-1:0] mul_a;
  logic [MUL_W-1:0] mul_b;
  logic [PROD_W-1:0] mul_p;
  logic [LOG_W-1:0] ldiff;
  assign ldiff = LOG2_FULL_SCALE - lres;

  always_comb begin
    unique case (state)
      ST_ACC: begin
        mul_a = MUL_W'(mag_r);
        mul_b = MUL_W'(mag_r);
      end
      ST_LOG_SQ: begin
        mul_a = mres;
        mul_b = mres;
      end
      ST_LOG_MUL: begin
        mul_a = MUL_W'(ldiff);
        mul_b = MUL_W'(DB_K);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = PROD_W'(mul_a) * PROD_W'(mul_b);

  // saturating accumulate and window end check
  logic [SUM_W:0] sum_ext;
  logic [SUM_W-1:0] sum_acc;
  logic [COUNT_WIDTH-1:0] count_inc;
  logic win_done;
  assign sum_ext = {1'b0, sum} + (SUM_W + 1)'(mul_q[2*LEVEL_W-1:0]);
  assign sum_acc = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
  assign count_inc = (&count) ? count : count + 1'b1;
  assign win_done = (CMP_W'(count_inc) >= CMP_W'(window_len)) || (&count_inc);

  // restoring divide step, one quotient bit per cycle
  logic [COUNT_WIDTH:0] div_trial;
  logic div_bit;
  logic [COUNT_WIDTH-1:0] div_rem_next;
  assign div_trial = {div_rem, sum[SUM_W-1]};
  assign div_bit = (div_trial >= {1'b0, count});
  assign div_rem_next = div_bit ? COUNT_WIDTH'(div_trial - {1'b0, count})
                                : div_trial[COUNT_WIDTH-1:0];

  // square root step, two operand bits per cycle
  logic [SQ_REM_W+1:0] sq_trial;
  logic [SQ_REM_W+1:0] sq_sub;
  logic sq_bit;
  logic [SQ_REM_W-1:0] sq_rem_next;
  logic [LEVEL_W-1:0] rms_val;
  assign sq_trial = {sq_rem, sum[SUM_W-1 -: 2]};
  assign sq_sub = (SQ_REM_W + 2)'({root, 2'b01});
  assign sq_bit = (sq_trial >= sq_sub);
  assign sq_rem_next = sq_bit ? SQ_REM_W'(sq_trial - sq_sub) : SQ_REM_W'(sq_trial);
  assign rms_val = (|root[ROOT_W-1:LEVEL_W]) ? FULL_SCALE : root[LEVEL_W-1:0];

  // log setup: pick level, normalize to Q30, integer part from msb position
  logic [LEVEL_W-1:0] log_x;
  logic [LEVEL_W-1:0] log_x_eff;
  logic [3:0] log_e;
  logic [MUL_W-1:0] m_init;
  logic log_full;
  logic log_floor;
  always_comb begin
    log_x = log_sel ? rms_val : peak;
    log_x_eff = (log_x == '0) ? LEVEL_W'(1) : log_x;
    log_e = '0;
    for (int k = 1; k < LEVEL_W; k++) begin
      if (log_x_eff[k]) log_e = 4'(k);
    end
    m_init = MUL_W'(log_x_eff) << (5'd30 - {1'b0, log_e});
    log_full = (log_x == FULL_SCALE);
    log_floor = log_sel && !(rms_val > floor_level);
  end

  // log squaring step, next fraction bit
  logic [MUL_W:0] sq_m;
  assign sq_m = mul_p[PROD_W-1:30];

  // dB rounding, saturation and the zero-level offset
  logic [PROD_W-1:0] rnd;
  logic [PROD_W-1:0] rnd_sh;
  logic [DB_MAG_W-1:0] db_mag;
  logic [DB_MAG_W-1:0] db_neg;
  logic [DB_W-1:0] db_val;
  always_comb begin
    rnd = mul_q + (PROD_W'(1) << (RND_SH - 1));
    rnd_sh = rnd >> RND_SH;
    db_mag = (rnd_sh > PROD_W'(DB_MAG_MAX)) ? DB_MAG_MAX : rnd_sh[DB_MAG_W-1:0];
    db_neg = DB_MAG_W'(0) - db_mag;
    if (zero_flag && (db_mag != DB_MAG_MAX)) db_neg = db_neg - 1'b1;
    db_val = db_neg[DB_W-1:0];
  end

  logic out_free;
  logic out_load;
  assign out_free = !out_valid || !out_stall;
  assign out_load = (state == ST_FINISH) && out_free;

  // sequencer, configuration and accumulators
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      step        <= '0;
      log_sel     <= 1'b0;
      log_rnd     <= 1'b0;
      out_valid   <= 1'b0;
      window_len  <= WINDOW_LEN_RST;
      floor_level <= FLOOR_LEVEL_RST;
      floor_db    <= FLOOR_DB_RST;
      peak        <= '0;
      sum         <= '0;
      count       <= '0;
    end else begin
      // register writes
      if (cfg_write) begin
        unique case (cfg_index)
          REG_WINDOW_LEN:  window_len  <= cfg_data;
          REG_FLOOR_LEVEL: floor_level <= cfg_data[14:0];
          REG_FLOOR_DB:    floor_db    <= cfg_data;
          default: ;
        endcase
      end

      // output beat loaded or taken
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;

      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (mag > peak) peak <= mag;
            state <= ST_ACC;
          end
        end
        ST_ACC: state <= ST_SUM;
        ST_SUM: begin
          sum   <= sum_acc;
          count <= count_inc;
          if (win_done) begin
            step  <= 6'(DIV_STEPS - 1);
            state <= ST_DIV;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV: begin
          sum  <= {sum[SUM_W-2:0], div_bit};
          step <= (step == '0) ? 6'(SQRT_STEPS - 1) : step - 1'b1;
          if (step == '0) state <= ST_SQRT;
        end
        ST_SQRT: begin
          sum  <= {sum[SUM_W-3:0], 2'b00};
          step <= step - 1'b1;
          if (step == '0) begin
            log_sel <= 1'b0;
            log_rnd <= 1'b0;
            state   <= ST_LOG_INIT;
          end
        end
        ST_LOG_INIT: begin
          if (log_full || log_floor) begin
            if (log_sel) begin
              state <= ST_FINISH;
            end else begin
              log_sel <= 1'b1;
            end
          end else begin
            step  <= 6'(LOG_FRAC - 1);
            state <= ST_LOG_SQ;
          end
        end
        ST_LOG_SQ: begin
          step <= step - 1'b1;
          if (step == '0) begin
            log_rnd <= 1'b0;
            state   <= ST_LOG_MUL;
          end
        end
        ST_LOG_MUL: begin
          // product register filled while log_rnd is low, rounded into the dB value while it is high
          log_rnd <= !log_rnd;
          if (log_rnd) begin
            if (log_sel) begin
              state <= ST_FINISH;
            end else begin
              log_sel <= 1'b1;
              state   <= ST_LOG_INIT;
            end
          end
        end
        ST_FINISH: begin
          if (out_free) begin
            peak  <= '0;
            sum   <= '0;
            count <= '0;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    mul_q <= mul_p;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) mag_r <= mag;
      end
      ST_SUM: div_rem <= '0;
      ST_DIV: begin
        div_rem <= div_rem_next;
        sq_rem  <= '0;
        root    <= '0;
      end
      ST_SQRT: begin
        sq_rem <= sq_rem_next;
        root   <= {root[ROOT_W-2:0], sq_bit};
      end
      ST_LOG_INIT: begin
        mres      <= m_init;
        lres      <= LOG_W'(log_e) << LOG_FRAC;
        zero_flag <= (log_x == '0);
        // an rms at or below the floor reports the floor even at full scale
        if (log_floor) begin
          rdb <= floor_db;
        end else if (log_full) begin
          if (log_sel) rdb <= '0;
          else pdb <= '0;
        end
      end
      ST_LOG_SQ: begin
        if (sq_m[MUL_W]) begin
          lres[step[4:0]] <= 1'b1;
          mres <= sq_m[MUL_W:1];
        end else begin
          mres <= sq_m[MUL_W-1:0];
        end
      end
      ST_LOG_MUL: begin
        if (log_rnd) begin
          if (log_sel) rdb <= db_val;
          else pdb <= db_val;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          peak_level <= peak;
          rms_level  <= rms_val;
          peak_db    <= pdb;
          rms_db     <= rdb;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/plm_check.sv
// port-level checks for the level meter and their bind to the top level
module plm_check (
  input logic                               clk,
  input logic                               rst,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic        [plm_pkg::LEVEL_W-1:0] peak_level,
  input logic        [plm_pkg::LEVEL_W-1:0] rms_level,
  input logic signed [plm_pkg::DB_W-1:0]    peak_db,
  input logic signed [plm_pkg::DB_W-1:0]    rms_db
);
  import plm_pkg::*;

  // a stalled result beat stays up
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable({peak_level, rms_level, peak_db, rms_db}))
    else $error("result payload changed while stalled");

  // the rms of a window never exceeds its peak
  a_rms_le_peak: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rms_level <= peak_level)
    else $error("rms level above peak level");

  // peak dB is never positive and is zero at full scale
  a_peak_db: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (peak_db <= 16'sd0) && (peak_level != FULL_SCALE || peak_db == 16'sd0))
    else $error("peak dB out of range");

endmodule

bind peak_rms_level_meter plm_check u_plm_check (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .peak_level (peak_level),
  .rms_level  (rms_level),
  .peak_db    (peak_db),
  .rms_db     (rms_db)
);

// File: test/testbench.sv
// self-checking testbench for the peak and rms level meter with random idling on both channels
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plm_pkg::*;

  localparam int          COUNT_W      = COUNT_WIDTH_DEF;
  localparam int          DB_FRAC      = DB_FRAC_BITS_DEF;
  localparam int unsigned LEVEL_TOP    = 32767;
  localparam longint unsigned DB_SCALE = 64'd101008905;
  localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_W) - 64'd1;
  localparam longint unsigned SUMSQ_TOP = (64'd1 << SUM_W) - 64'd1;
  // index past the last register, the block ignores it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  // idle cycles after the last result before touching registers
  localparam int          SETTLE_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT   = 1500000;

  typedef struct packed {
    logic        [LEVEL_W-1:0] peak_level;
    logic        [LEVEL_W-1:0] rms_level;
    logic signed [DB_W-1:0]    peak_db;
    logic signed [DB_W-1:0]    rms_db;
  } level_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic signed [15:0]    sample = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [LEVEL_W-1:0]    peak_level;
  logic [LEVEL_W-1:0]    rms_level;
  logic signed [DB_W-1:0] peak_db;
  logic signed [DB_W-1:0] rms_db;
  logic                  cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow registers and window accumulators of the meter
  logic [15:0]       win_len;
  logic [14:0]       floor_lvl;
  logic [15:0]       floor_dbv;
  int unsigned       acc_peak;
  longint unsigned   acc_sumsq;
  longint unsigned   acc_count;

  level_result_t     window_levels_due[$];
  int unsigned       send_idle_pct = 0;
  int unsigned       recv_idle_pct = 0;
  int unsigned       mismatches = 0;
  int unsigned       samples_sent = 0;
  int unsigned       windows_checked = 0;
  int unsigned       settings_used = 0;
  int unsigned       cycles = 0;

  peak_rms_level_meter #(
    .COUNT_WIDTH (COUNT_WIDTH_DEF),
    .DB_FRAC_BITS(DB_FRAC_BITS_DEF)
  ) u_top (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .sample    (sample),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .peak_level(peak_level),
    .rms_level (rms_level),
    .peak_db   (peak_db),
    .rms_db    (rms_db),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // run guard
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d windows still due", cycles,
               window_levels_due.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // log2 in Q24 by repeated squaring of the normalized level
  function automatic longint unsigned log2_q24_of(input int unsigned x);
    int unsigned     e;
    longint unsigned m;
    longint unsigned acc;
    int              i;
    e = 0;
    while (e < 31 && (x >> (e + 1)) != 0) e++;
    m = longint'(x) << (30 - e);
    acc = longint'(e) << 24;
    for (i = 23; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= 64'h8000_0000) begin
        acc |= 64'd1 << i;
        m = m >> 1;
      end
    end
    return acc;
  endfunction

  // level to dB below full scale in 1/256 dB
  function automatic logic [15:0] level_to_db(input int unsigned x);
    longint unsigned diff;
    longint unsigned prod;
    longint unsigned mag;
    longint          v;
    bit              was_zero;
    if (x >= LEVEL_TOP) return 16'd0;
    was_zero = (x == 0);
    if (was_zero) x = 1;
    diff = log2_q24_of(LEVEL_TOP) - log2_q24_of(x);
    prod = diff * DB_SCALE;
    mag = (prod + (64'd1 << (47 - DB_FRAC))) >> (48 - DB_FRAC);
    if (mag > 64'd32768) mag = 64'd32768;
    v = -longint'(mag);
    if (was_zero && v > -32768) v = v - 1;
    return v[15:0];
  endfunction

  function automatic int unsigned floor_root(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    int              b;
    r = 0;
    for (b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return 32'(r);
  endfunction

  // fold one sample into the window, queue the levels when the window closes
  function automatic void predict_level_window(input logic [15:0] raw);
    int unsigned     mag;
    longint unsigned sq;
    longint unsigned mean;
    int unsigned     rms;
    level_result_t   lv;
    mag = raw[15] ? (32'h10000 - raw) : raw;
    if (mag > LEVEL_TOP) mag = LEVEL_TOP;
    if (mag > acc_peak) acc_peak = mag;
    sq = longint'(mag);
    acc_sumsq = acc_sumsq + sq * sq;
    if (acc_sumsq > SUMSQ_TOP) acc_sumsq = SUMSQ_TOP;
    if (acc_count < COUNT_TOP) acc_count++;
    if (acc_count < longint'(win_len) && acc_count < COUNT_TOP) return;
    mean = acc_sumsq / acc_count;
    rms = floor_root(mean);
    if (rms > LEVEL_TOP) rms = LEVEL_TOP;
    lv.peak_level = acc_peak[14:0];
    lv.rms_level  = rms[14:0];
    lv.peak_db    = level_to_db(acc_peak);
    lv.rms_db     = (rms > floor_lvl) ? level_to_db(rms) : floor_dbv;
    window_levels_due.push_back(lv);
    acc_peak = 0;
    acc_sumsq = 0;
    acc_count = 0;
  endfunction

  // result side: random stall, compare every beat against the oldest window
  always @(posedge clk) begin
    level_result_t lv;
    if (!rst && out_valid && !out_stall) begin
      if (window_levels_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: peak %0d rms %0d peak_db %0d rms_db %0d",
                   peak_level, rms_level, peak_db, rms_db);
      end else begin
        lv = window_levels_due.pop_front();
        windows_checked++;
        if (peak_level !== lv.peak_level || rms_level !== lv.rms_level ||
            peak_db !== lv.peak_db || rms_db !== lv.rms_db) begin
          mismatches++;
          if (mismatches <= 10)
            $display("window %0d mismatch: peak %0d/%0d rms %0d/%0d peak_db %0d/%0d rms_db %0d/%0d (exp/got)",
                     windows_checked, lv.peak_level, peak_level, lv.rms_level, rms_level,
                     lv.peak_db, peak_db, lv.rms_db, rms_db);
        end
      end
    end
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // send one sample beat, idling first at random
  task automatic push_sample(input logic [15:0] s);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_level_window(s);
    samples_sent++;
  endtask

  // sender pauses until every due window has come out
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (window_levels_due.size() != 0) @(posedge clk);
  endtask

  // meter idle: nothing due and the last sample fully absorbed
  task automatic settle_meter();
    hold_until_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] d);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_WINDOW_LEN:  win_len   = d;
      REG_FLOOR_LEVEL: floor_lvl = d[14:0];
      REG_FLOOR_DB:    floor_dbv = d;
      default: ;
    endcase
    settings_used++;
    @(posedge clk);
  endtask

  // sample of a given amplitude, full range when amp is zero, extremes now and then
  function automatic logic [15:0] pick_sample(input int unsigned amp);
    int s;
    if ($urandom_range(9) == 0) begin
      case ($urandom_range(4))
        0: return 16'h8000;
        1: return 16'h7fff;
        2: return 16'h8001;
        3: return 16'hffff;
        default: return 16'h0000;
      endcase
    end
    if (amp == 0) return 16'($urandom);
    s = int'($urandom_range(2 * amp)) - int'(amp);
    return s[15:0];
  endfunction

  // reset window length holds the window open, a shorter one then closes it
  // at the reset floor values
  task automatic test_reset_defaults();
    int i;
    for (i = 0; i < 200; i++) push_sample(pick_sample(60));
    settle_meter();
    write_register(REG_WINDOW_LEN, 16'd150);
    push_sample(pick_sample(60));
    settle_meter();
  endtask

  // field extremes, zero level, most negative sample, zero window, unused index
  task automatic test_directed();
    settle_meter();
    write_register(REG_WINDOW_LEN, 16'd1);
    write_register(REG_FLOOR_LEVEL, 16'd0);
    write_register(REG_FLOOR_DB, 16'hA5B0);
    push_sample(16'h7fff);
    push_sample(16'h8000);
    push_sample(16'h8001);
    push_sample(16'h0000);
    push_sample(16'h0001);
    push_sample(16'hffff);
    push_sample(16'h4000);
    push_sample(16'hc000);
    push_sample(16'h5555);
    push_sample(16'haaaa);
    push_sample(16'h0021);
    push_sample(16'h0022);
    settle_meter();
    // floor at full scale, upper data bit of the level write dropped
    write_register(REG_FLOOR_LEVEL, 16'hffff);
    write_register(REG_FLOOR_DB, 16'h0000);
    push_sample(16'h7fff);
    push_sample(16'h1234);
    settle_meter();
    // zero window length closes on every sample
    write_register(REG_WINDOW_LEN, 16'd0);
    push_sample(16'h8000);
    push_sample(16'h0100);
    settle_meter();
    write_register(REG_UNUSED, 16'hffff);
    write_register(REG_WINDOW_LEN, 16'd3);
    write_register(REG_FLOOR_LEVEL, 16'd2);
    push_sample(16'h7fff);
    push_sample(16'h0000);
    push_sample(16'h8000);
    push_sample(16'h0001);
    push_sample(16'h0002);
    push_sample(16'h0003);
    settle_meter();
  endtask

  // random settings and bursts of samples under one idling profile
  task automatic test_random_phase(input int unsigned s_pct, input int unsigned r_pct,
                                   input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned amp;
    int unsigned i;
    logic [15:0] d;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n_items) begin
      settle_meter();
      case ($urandom_range(19))
        0: d = 16'd0;
        1: d = 16'd1;
        2: d = 16'($urandom_range(100, 400));
        default: d = 16'($urandom_range(2, 16));
      endcase
      write_register(REG_WINDOW_LEN, d);
      case ($urandom_range(9))
        0: d = 16'd0;
        1: d = 16'h7fff;
        default: d = 16'($urandom_range(0, 3000));
      endcase
      d[15] = 1'($urandom_range(1));
      write_register(REG_FLOOR_LEVEL, d);
      case ($urandom_range(5))
        0: d = 16'h0000;
        1: d = 16'hA5B0;
        default: d = 16'(-int'($urandom_range(0, 23120)));
      endcase
      write_register(REG_FLOOR_DB, d);
      if ($urandom_range(7) == 0) write_register(REG_UNUSED, 16'($urandom));
      case ($urandom_range(3))
        0: amp = 0;
        1: amp = 40;
        2: amp = 300;
        default: amp = 5000;
      endcase
      burst = $urandom_range(20, 60);
      for (i = 0; i < burst; i++) begin
        push_sample(pick_sample(amp));
        sent++;
        if (i == burst / 2 && $urandom_range(3) == 0) hold_until_drained();
      end
    end
    settle_meter();
  endtask

  initial begin
    win_len   = WINDOW_LEN_RST;
    floor_lvl = FLOOR_LEVEL_RST;
    floor_dbv = FLOOR_DB_RST;
    acc_peak  = 0;
    acc_sumsq = 0;
    acc_count = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    send_idle_pct = 14;
    recv_idle_pct = 51;
    test_reset_defaults();
    test_directed();
    test_random_phase(14, 51, 230);
    test_random_phase(51, 14, 230);
    test_random_phase(0, 0, 230);
    settle_meter();
    $display("run covered %0d samples, %0d windows checked, %0d register writes",
             samples_sent, windows_checked, settings_used);
    $display("window lengths from zero to a few hundred, floors and idling on both sides");
    if (mismatches == 0 && window_levels_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d windows still due", mismatches, window_levels_due.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
design/plm_pkg.sv
design/peak_rms_level_meter.sv
design/plm_check.sv
test/testbench.sv
